>>> hw/rtl/bounded_stack_bottom_increment_top_assert.svh
// Assertion macros for the bounded stack checker.
// Used by bsbi_checker.sv; expects clk and rst_n in scope.
`ifndef BOUNDED_STACK_BOTTOM_INCREMENT_TOP_ASSERT_SVH
`define BOUNDED_STACK_BOTTOM_INCREMENT_TOP_ASSERT_SVH

// Clocked check, off while reset is held.
`define BSBI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs through reset.
`define BSBI_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/bsbi_pkg.sv
// Shared types and constants for the bounded stack block.
// No dependencies.
package bsbi_pkg;

  localparam int DATA_W  = 32;
  localparam int CFG_W   = 11;
  localparam int COUNT_W = 11;

  localparam logic [CFG_W-1:0]  MAX_DEPTH_RST = 11'd1024;
  localparam logic [DATA_W-1:0] EMPTY_VALUE   = '1;

  typedef enum logic [1:0] {
    REQ_PUSH = 2'd0,
    REQ_POP  = 2'd1,
    REQ_INC  = 2'd2,
    REQ_NONE = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_PUSH,
    CELL_POP,
    CELL_INC
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [DATA_W-1:0] inc_value;
  } cell_ctl_t;

endpackage

>>> hw/rtl/bsbi_if.sv
// Channel interfaces for the bounded stack block: request, result and config write.
// Depends on bsbi_pkg.
interface bsbi_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          req_type;
  logic signed [bsbi_pkg::DATA_W-1:0]  push_value;
  logic [bsbi_pkg::COUNT_W-1:0]        inc_count;
  logic signed [bsbi_pkg::DATA_W-1:0]  inc_value;

  modport source (output valid, req_type, push_value, inc_count, inc_value, input ready);
  modport sink   (input valid, req_type, push_value, inc_count, inc_value, output ready);
endinterface

interface bsbi_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [bsbi_pkg::DATA_W-1:0]  pop_value;
  logic                                was_empty;

  modport source (output valid, pop_value, was_empty, input ready);
  modport sink   (input valid, pop_value, was_empty, output ready);
endinterface

interface bsbi_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bsbi_pkg::CFG_W-1:0]     max_depth;

  modport source (output valid, max_depth, input ready);
  modport sink   (input valid, max_depth, output ready);
endinterface

>>> hw/rtl/bsbi_cell.sv
// One stack cell: holds the entry at a fixed depth from the top.
// Depends on bsbi_pkg.
module bsbi_cell #(
  parameter int CNT_W = 11,
  parameter int IDX   = 0
) (
  input  logic                        clk,
  input  bsbi_pkg::cell_ctl_t         ctl,
  input  logic [CNT_W-1:0]            inc_base,
  input  logic [bsbi_pkg::DATA_W-1:0] up_value,
  input  logic [bsbi_pkg::DATA_W-1:0] down_value,
  output logic [bsbi_pkg::DATA_W-1:0] value
);

  localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

  logic [bsbi_pkg::DATA_W-1:0] value_r;

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      bsbi_pkg::CELL_PUSH: value_r <= up_value;
      bsbi_pkg::CELL_POP:  value_r <= down_value;
      bsbi_pkg::CELL_INC: begin
        if (IDX_C >= inc_base) begin
          value_r <= value_r + ctl.inc_value;
        end
      end
      bsbi_pkg::CELL_HOLD: value_r <= value_r;
      default:             value_r <= value_r;
    endcase
  end

  assign value = value_r;

endmodule

>>> hw/rtl/bounded_stack_bottom_increment_top.sv
// Bounded stack with bottom increment: top level, request decode and cell row.
// Depends on bsbi_pkg, bsbi_if and bsbi_cell.
//
// Channels: in_if carries one request item (push, pop or increment bottom
// entries), out_if carries one result item for each pop, cfg_if writes the
// capacity register max_depth (always ready, write only while idle).
// Entries sit in a row of cells, the top of stack in cell 0. A push shifts the
// row down by one, a pop shifts it up; an increment adds to every cell at or
// below the uppermost selected entry, all in the same cycle.
// Throughput: one request item per cycle when not stalled. A pop result reaches
// the output register the cycle after acceptance; push and increment give none.
// Stall: while a result waits and out_if.ready is low, in_if.ready is low;
// it returns as soon as the result is taken.
// Reset: the entry count clears to empty, max_depth returns to 1024 and the
// output register empties; cell contents are not cleared and need no sweep.
module bounded_stack_bottom_increment_top #(
  parameter int STACK_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  bsbi_in_if.sink     in_if,
  bsbi_out_if.source  out_if,
  bsbi_cfg_if.sink    cfg_if
);

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int CMP_W = (CNT_W > bsbi_pkg::COUNT_W) ? CNT_W : bsbi_pkg::COUNT_W;
  localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(STACK_DEPTH);

  logic [bsbi_pkg::CFG_W-1:0]  max_depth_r;
  logic [CNT_W-1:0]            cnt_r;
  logic [CNT_W-1:0]            cnt_nxt;
  logic                        out_valid_r;
  logic [bsbi_pkg::DATA_W-1:0] pop_value_r;
  logic                        was_empty_r;

  logic                        accept;
  bsbi_pkg::req_t              req;
  logic [CMP_W-1:0]            cnt_ext;
  logic [CMP_W-1:0]            cap_ext;
  logic [CMP_W-1:0]            max_ext;
  logic [CMP_W-1:0]            kcnt_ext;
  logic [CMP_W-1:0]            n_ext;
  logic [CNT_W-1:0]            inc_base;
  logic                        push_ok;
  logic                        empty;
  bsbi_pkg::cell_ctl_t         ctl;

  logic [bsbi_pkg::DATA_W-1:0] cell_val [STACK_DEPTH];

  assign in_if.ready  = !out_valid_r || out_if.ready;
  assign cfg_if.ready = 1'b1;
  assign accept       = in_if.valid && in_if.ready;
  assign req          = bsbi_pkg::req_t'(in_if.req_type);

  assign cnt_ext  = CMP_W'(cnt_r);
  assign max_ext  = CMP_W'(max_depth_r);
  assign cap_ext  = (max_ext > DEPTH_C) ? DEPTH_C : max_ext;
  assign kcnt_ext = CMP_W'(in_if.inc_count);
  assign n_ext    = (kcnt_ext > cnt_ext) ? cnt_ext : kcnt_ext;
  assign inc_base = cnt_r - n_ext[CNT_W-1:0];
  assign push_ok  = cnt_ext < cap_ext;
  assign empty    = (cnt_r == '0);

  always_comb begin
    ctl.op        = bsbi_pkg::CELL_HOLD;
    ctl.inc_value = in_if.inc_value;
    cnt_nxt       = cnt_r;
    if (accept) begin
      unique case (req)
        bsbi_pkg::REQ_PUSH: begin
          if (push_ok) begin
            ctl.op  = bsbi_pkg::CELL_PUSH;
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
        bsbi_pkg::REQ_POP: begin
          if (!empty) begin
            ctl.op  = bsbi_pkg::CELL_POP;
            cnt_nxt = cnt_r - CNT_W'(1);
          end
        end
        bsbi_pkg::REQ_INC: begin
          if (n_ext != '0) begin
            ctl.op = bsbi_pkg::CELL_INC;
          end
        end
        bsbi_pkg::REQ_NONE: ctl.op = bsbi_pkg::CELL_HOLD;
        default:            ctl.op = bsbi_pkg::CELL_HOLD;
      endcase
    end
  end

  for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
    logic [bsbi_pkg::DATA_W-1:0] up_v;
    logic [bsbi_pkg::DATA_W-1:0] down_v;
    if (g == 0) begin : g_first
      assign up_v = in_if.push_value;
    end else begin : g_mid
      assign up_v = cell_val[g-1];
    end
    if (g == STACK_DEPTH - 1) begin : g_last
      assign down_v = '0;
    end else begin : g_inner
      assign down_v = cell_val[g+1];
    end
    bsbi_cell #(
      .CNT_W (CNT_W),
      .IDX   (g)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .inc_base   (inc_base),
      .up_value   (up_v),
      .down_value (down_v),
      .value      (cell_val[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      max_depth_r <= bsbi_pkg::MAX_DEPTH_RST;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (cfg_if.valid && cfg_if.ready) begin
        max_depth_r <= cfg_if.max_depth;
      end
      if (accept && req == bsbi_pkg::REQ_POP) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && req == bsbi_pkg::REQ_POP) begin
      pop_value_r <= empty ? bsbi_pkg::EMPTY_VALUE : cell_val[0];
      was_empty_r <= empty;
    end
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.pop_value = pop_value_r;
  assign out_if.was_empty = was_empty_r;

endmodule

>>> hw/rtl/bsbi_checker.sv
// Port-level checker for the bounded stack top level, with its bind.
// Depends on bsbi_pkg and the assertion macro header.
`include "bounded_stack_bottom_increment_top_assert.svh"

module bsbi_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [1:0]                  in_req_type,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [bsbi_pkg::DATA_W-1:0] out_pop_value,
  input logic                        out_was_empty
);

  `BSBI_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_pop_value), "result item changed while stalled")
  `BSBI_ASSERT_RST(a_rst_clear, !rst_n |=> !out_valid, "result valid after reset")
  `BSBI_ASSERT(a_rose_on_pop, $rose(out_valid) |-> $past(in_valid && in_ready && in_req_type == bsbi_pkg::REQ_POP), "result item without a pop")
  `BSBI_ASSERT(a_empty_value, out_valid && out_was_empty |-> out_pop_value == bsbi_pkg::EMPTY_VALUE, "empty pop value is not all ones")

endmodule

bind bounded_stack_bottom_increment_top bsbi_checker u_bsbi_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_if.valid),
  .in_ready      (in_if.ready),
  .in_req_type   (in_if.req_type),
  .out_valid     (out_if.valid),
  .out_ready     (out_if.ready),
  .out_pop_value (out_if.pop_value),
  .out_was_empty (out_if.was_empty)
);

>>> verif/tb.sv
`timescale 1ns / 1ps
// Testbench for bounded_stack_bottom_increment_top: directed table, then random phases.
// Depends on bsbi_pkg, bsbi_if and the top level; checks pops against a lazy-increment stack model.
module tb;

  localparam int DEPTH       = 1024;
  localparam int SETTLE      = 4;
  localparam int CYCLE_LIMIT = 600000;
  localparam int REPORT_MAX  = 10;
  localparam int FILL_PUSHES = 120;

  typedef struct {
    bit                          present;
    logic [bsbi_pkg::DATA_W-1:0] value;
    logic                        empty;
  } pop_result_t;

  typedef struct {
    bsbi_pkg::req_t               op;
    logic [bsbi_pkg::DATA_W-1:0]  pval;
    logic [bsbi_pkg::COUNT_W-1:0] kcnt;
    logic [bsbi_pkg::DATA_W-1:0]  ival;
    bit                           pinned;
    logic [bsbi_pkg::DATA_W-1:0]  pin_value;
    logic                         pin_empty;
  } stim_row_t;

  logic clk;
  logic rst_n;

  bsbi_in_if  in_ch ();
  bsbi_out_if out_ch ();
  bsbi_cfg_if cfg_ch ();

  bounded_stack_bottom_increment_top #(
    .STACK_DEPTH(DEPTH)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  logic [bsbi_pkg::DATA_W-1:0] stack_vals [DEPTH];
  logic [bsbi_pkg::DATA_W-1:0] stack_incs [DEPTH];
  int unsigned                 stack_count;
  logic [bsbi_pkg::CFG_W-1:0]  cap_reg;
  pop_result_t                 pending_pops [$];

  int fail_count;
  int cycle_count;
  int burst_left;
  bit tx_calm;
  int rx_mode;
  int rx_hold;
  int rx_cycle;

  stim_row_t directed_rows [] = '{
    '{bsbi_pkg::REQ_POP,  32'h0,        11'd0,    32'h0,        1'b1,
      bsbi_pkg::EMPTY_VALUE, 1'b1},
    '{bsbi_pkg::REQ_NONE, 32'h0,        11'd0,    32'h0,        1'b0, 32'h0, 1'b0},
    '{bsbi_pkg::REQ_INC,  32'h0,        11'd5,    32'h7,        1'b0, 32'h0, 1'b0},
    '{bsbi_pkg::REQ_PUSH, 32'h7fffffff, 11'd0,    32'h0,        1'b0, 32'h0, 1'b0},
    '{bsbi_pkg::REQ_PUSH, 32'h80000000, 11'd0,    32'h0,        1'b0, 32'h0, 1'b0},
    '{bsbi_pkg::REQ_PUSH, 32'h0,        11'd0,    32'h0,        1'b0, 32'h0, 1'b0},
    '{bsbi_pkg::REQ_PUSH, 32'hffffffff, 11'd0,    32'h0,        1'b0, 32'h0, 1'b0},
    '{bsbi_pkg::REQ_INC,  32'h0,        11'd0,    32'h123,      1'b0, 32'h0, 1'b0},
    '{bsbi_pkg::REQ_INC,  32'h0,        11'd2,    32'h1,        1'b0, 32'h0, 1'b0},
    '{bsbi_pkg::REQ_INC,  32'h0,        11'd2047, 32'h80000000, 1'b0, 32'h0, 1'b0},
    '{bsbi_pkg::REQ_INC,  32'h0,        11'd1024, 32'hffffffff, 1'b0, 32'h0, 1'b0},
    '{bsbi_pkg::REQ_NONE, 32'hffffffff, 11'd2047, 32'hffffffff, 1'b0, 32'h0, 1'b0},
    '{bsbi_pkg::REQ_POP,  32'h0,        11'd0,    32'h0,        1'b0, 32'h0, 1'b0},
    '{bsbi_pkg::REQ_INC,  32'h0,        11'd1,    32'h7fffffff, 1'b0, 32'h0, 1'b0},
    '{bsbi_pkg::REQ_POP,  32'h0,        11'd0,    32'h0,        1'b0, 32'h0, 1'b0},
    '{bsbi_pkg::REQ_POP,  32'h0,        11'd0,    32'h0,        1'b0, 32'h0, 1'b0},
    '{bsbi_pkg::REQ_POP,  32'h0,        11'd0,    32'h0,        1'b0, 32'h0, 1'b0},
    '{bsbi_pkg::REQ_POP,  32'h0,        11'd0,    32'h0,        1'b1,
      bsbi_pkg::EMPTY_VALUE, 1'b1},
    '{bsbi_pkg::REQ_INC,  32'h0,        11'd2047, 32'h5,        1'b0, 32'h0, 1'b0},
    '{bsbi_pkg::REQ_PUSH, 32'h7fffffff, 11'd0,    32'h0,        1'b0, 32'h0, 1'b0},
    '{bsbi_pkg::REQ_POP,  32'h0,        11'd0,    32'h0,        1'b1, 32'h7fffffff, 1'b0},
    '{bsbi_pkg::REQ_POP,  32'h0,        11'd0,    32'h0,        1'b1,
      bsbi_pkg::EMPTY_VALUE, 1'b1}
  };

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic pop_result_t apply_request(input bsbi_pkg::req_t op,
                                                input logic [bsbi_pkg::DATA_W-1:0] pval,
                                                input logic [bsbi_pkg::COUNT_W-1:0] kcnt,
                                                input logic [bsbi_pkg::DATA_W-1:0] ival);
    pop_result_t res;
    int unsigned capacity;
    int unsigned span;
    int unsigned t;
    res = '{1'b0, '0, 1'b0};
    capacity = (cap_reg > DEPTH) ? DEPTH : cap_reg;
    case (op)
      bsbi_pkg::REQ_PUSH: begin
        if (stack_count < capacity) begin
          stack_vals[stack_count] = pval;
          stack_incs[stack_count] = '0;
          stack_count++;
        end
      end
      bsbi_pkg::REQ_POP: begin
        res.present = 1'b1;
        if (stack_count == 0) begin
          res.value = bsbi_pkg::EMPTY_VALUE;
          res.empty = 1'b1;
        end else begin
          t = stack_count - 1;
          res.value = stack_vals[t] + stack_incs[t];
          if (t > 0) stack_incs[t-1] = stack_incs[t-1] + stack_incs[t];
          stack_count = t;
        end
      end
      bsbi_pkg::REQ_INC: begin
        span = (kcnt > stack_count) ? stack_count : kcnt;
        if (span > 0) stack_incs[span-1] = stack_incs[span-1] + ival;
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic logic [bsbi_pkg::DATA_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'h7fffffff;
      1:       return 32'h80000000;
      2:       return 32'hffffffff;
      3:       return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [bsbi_pkg::COUNT_W-1:0] pick_span();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 7) return bsbi_pkg::COUNT_W'($urandom_range(0, stack_count + 2));
    if (sel < 9) return bsbi_pkg::COUNT_W'($urandom_range(0, 2047));
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return bsbi_pkg::COUNT_W'(stack_count);
      2:       return 11'd1024;
      default: return 11'd2047;
    endcase
  endfunction

  task automatic send_request(input bsbi_pkg::req_t op,
                              input logic [bsbi_pkg::DATA_W-1:0] pval,
                              input logic [bsbi_pkg::COUNT_W-1:0] kcnt,
                              input logic [bsbi_pkg::DATA_W-1:0] ival,
                              input bit pinned, input logic [bsbi_pkg::DATA_W-1:0] pin_value,
                              input logic pin_empty);
    pop_result_t res;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = tx_calm ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_ch.valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_ch.valid      = 1'b1;
    in_ch.req_type   = op;
    in_ch.push_value = pval;
    in_ch.inc_count  = kcnt;
    in_ch.inc_value  = ival;
    do @(posedge clk); while (!in_ch.ready);
    res = apply_request(op, pval, kcnt, ival);
    if (res.present) begin
      if (pinned) begin
        res.value = pin_value;
        res.empty = pin_empty;
      end
      pending_pops.push_back(res);
    end
  endtask

  task automatic drain_pops();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_pops.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic set_capacity(input logic [bsbi_pkg::CFG_W-1:0] depth);
    drain_pops();
    @(negedge clk);
    cfg_ch.valid     = 1'b1;
    cfg_ch.max_depth = depth;
    do @(posedge clk); while (!cfg_ch.ready);
    cap_reg = depth;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic run_mix(input int items, input int w_push, input int w_pop, input int w_inc);
    int roll;
    bsbi_pkg::req_t op;
    tx_calm = ($urandom_range(0, 2) == 0);
    for (int i = 0; i < items; i++) begin
      roll = $urandom_range(0, w_push + w_pop + w_inc + 4);
      if (roll < w_push) op = bsbi_pkg::REQ_PUSH;
      else if (roll < w_push + w_pop) op = bsbi_pkg::REQ_POP;
      else if (roll < w_push + w_pop + w_inc) op = bsbi_pkg::REQ_INC;
      else op = bsbi_pkg::REQ_NONE;
      send_request(op, pick_word(), pick_span(), pick_word(), 1'b0, '0, 1'b0);
    end
  endtask

  always @(negedge clk) begin
    rx_cycle++;
    if (rx_cycle % 256 == 0) rx_mode = $urandom_range(0, 2);
    if (rx_hold > 0) begin
      out_ch.ready = 1'b0;
      rx_hold--;
    end else begin
      out_ch.ready = 1'b1;
      if (rx_mode == 1 && $urandom_range(0, 3) == 0) rx_hold = $urandom_range(1, 3);
      else if (rx_mode == 2 && $urandom_range(0, 1) == 0) rx_hold = $urandom_range(1, 8);
    end
  end

  always @(posedge clk) begin
    pop_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_pops.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_MAX)
          $display("unexpected pop result: value %h empty %b", out_ch.pop_value,
                   out_ch.was_empty);
      end else begin
        want = pending_pops.pop_front();
        if (out_ch.pop_value !== want.value || out_ch.was_empty !== want.empty) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("pop result differs: expected value %h empty %b, got value %h empty %b",
                     want.value, want.empty, out_ch.pop_value, out_ch.was_empty);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("bounded_stack_bottom_increment_top: mismatch");
      $finish;
    end
  end

  initial begin
    int pushes;
    logic [bsbi_pkg::CFG_W-1:0] caps [6];
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.req_type   = bsbi_pkg::REQ_NONE;
    in_ch.push_value = '0;
    in_ch.inc_count  = '0;
    in_ch.inc_value  = '0;
    out_ch.ready     = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.max_depth = '0;
    stack_count      = 0;
    cap_reg          = bsbi_pkg::MAX_DEPTH_RST;
    fail_count       = 0;
    cycle_count      = 0;
    burst_left       = 0;
    tx_calm          = 1'b0;
    rx_mode          = 1;
    rx_hold          = 0;
    rx_cycle         = 0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i])
      send_request(directed_rows[i].op, directed_rows[i].pval, directed_rows[i].kcnt,
                   directed_rows[i].ival, directed_rows[i].pinned,
                   directed_rows[i].pin_value, directed_rows[i].pin_empty);

    set_capacity(11'd0);
    run_mix(40, 50, 30, 15);
    set_capacity(11'd1);
    run_mix(60, 45, 35, 15);

    // push with capacity beyond the store
    set_capacity(11'd2047);
    tx_calm = 1'b0;
    pushes = 0;
    while (pushes < FILL_PUSHES) begin
      if ($urandom_range(0, 9) == 0) begin
        send_request(bsbi_pkg::REQ_INC, pick_word(), pick_span(), pick_word(),
                     1'b0, '0, 1'b0);
      end else begin
        send_request(bsbi_pkg::REQ_PUSH, pick_word(), pick_span(), pick_word(),
                     1'b0, '0, 1'b0);
        pushes++;
      end
    end

    // lower capacity below the count, then pop down to six entries
    set_capacity(11'd4);
    run_mix(40, 60, 20, 15);
    set_capacity(11'd1024);
    while (stack_count > 6)
      send_request(bsbi_pkg::REQ_POP, pick_word(), pick_span(), pick_word(), 1'b0, '0, 1'b0);

    caps = '{11'd2, 11'd7, 11'd16, 11'd1024, 11'd1, 11'd0};
    caps[5] = bsbi_pkg::CFG_W'($urandom_range(1, 40));
    foreach (caps[i]) begin
      set_capacity(caps[i]);
      run_mix(50, 45, 35, 15);
    end

    drain_pops();
    if (fail_count == 0 && pending_pops.size() == 0) begin
      $display("bounded_stack_bottom_increment_top: match");
    end else begin
      $display("bounded_stack_bottom_increment_top: mismatch");
    end
    $finish;
  end

endmodule
